[design/samp_pkg.sv]
package samp_pkg;

  localparam int SineSteps = 16;
  localparam int DivSteps  = 32;

  localparam logic [31:0] K2pi  = 32'hA2F9836E;
  localparam logic [31:0] PihQ30 = 32'd1686629713;
  localparam logic [31:0] PiQ30  = 32'd3373259426;
  localparam logic [31:0] IpiQ32 = 32'd1367130551;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  localparam logic [1:0] PhAccel  = 2'd0;
  localparam logic [1:0] PhCruise = 2'd1;
  localparam logic [1:0] PhDecel  = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  localparam logic [1:0] RegLength = 2'd0;
  localparam logic [1:0] RegSpeed  = 2'd1;
  localparam logic [1:0] RegAccel  = 2'd2;

  // arctangent table in signed Q3.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // one pipeline token of the sample path
  typedef struct packed {
    logic        vld;
    logic [1:0]  ph;
    logic [33:0] num;   // elapsed time in the sine phase, or t - t1 when cruising
    logic [31:0] t;
    logic [31:0] base;  // distance to add at the end
  } tok_t;

  // one step of the per-sample divider f = u*2^32/t1
  typedef struct packed {
    tok_t        tk;
    logic [33:0] rem;
    logic [32:0] quo;
  } div_t;

  typedef struct packed {
    tok_t               tk;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cor_t;

endpackage

[design/samp_div_cell.sv]
// one restoring step of u*2^32 / t1
module samp_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [33:0]       t1,
  input  samp_pkg::div_t    din,
  output samp_pkg::div_t    dout
);
  logic [34:0] trial;
  samp_pkg::div_t nxt;

  always_comb begin
    nxt = din;
    trial = {din.rem, 1'b0} - {1'b0, t1};
    if (!trial[34]) begin
      nxt.rem = trial[33:0];
      nxt.quo = {din.quo[31:0], 1'b1};
    end else begin
      nxt.rem = {din.rem[32:0], 1'b0};
      nxt.quo = {din.quo[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tk.vld <= 1'b0;
    end else begin
      dout.tk.vld <= din.tk.vld;
    end
    dout.tk.ph   <= nxt.tk.ph;
    dout.tk.num  <= nxt.tk.num;
    dout.tk.t    <= nxt.tk.t;
    dout.tk.base <= nxt.tk.base;
    dout.rem     <= nxt.rem;
    dout.quo     <= nxt.quo;
  end
endmodule

[design/samp_cordic_cell.sv]
// one rotation step, shift index given by the cell position
module samp_cordic_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     idx,
  input  samp_pkg::cor_t din,
  output samp_pkg::cor_t dout
);
  logic signed [33:0] dx, dy, a;
  samp_pkg::cor_t nxt;

  always_comb begin
    dx = din.y >>> idx;
    dy = din.x >>> idx;
    a  = samp_pkg::atan_q30(idx);
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - a;
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tk.vld <= 1'b0;
    end else begin
      dout.tk.vld <= din.tk.vld;
    end
    dout.tk.ph   <= nxt.tk.ph;
    dout.tk.num  <= nxt.tk.num;
    dout.tk.t    <= nxt.tk.t;
    dout.tk.base <= nxt.tk.base;
    dout.x       <= nxt.x;
    dout.y       <= nxt.y;
    dout.z       <= nxt.z;
  end
endmodule

[design/samp_derive.sv]
// derives vr, t1, t2, T, s1, s2 from the registers with a small sequencer
module samp_derive (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] len,
  input  logic [31:0] spd,
  input  logic [31:0] acc,
  output logic        busy,
  output logic [31:0] vr,
  output logic [33:0] t1,
  output logic [33:0] t2,
  output logic [33:0] tt,
  output logic [31:0] s1,
  output logic [31:0] s2
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_PROD = 8'b00000010, S_M2 = 8'b00000100,
    S_SQRT = 8'b00001000, S_VT   = 8'b00010000, S_DIV1 = 8'b00100000,
    S_DIV2 = 8'b01000000, S_FIN  = 8'b10000000
  } st_t;

  st_t st;
  logic [63:0] prod, m2, dnum;
  logic [63:0] srem;
  logic [31:0] sres;
  logic [4:0]  scnt;
  logic [63:0] drem, dquo;
  logic [31:0] dden;
  logic [6:0]  dcnt;
  logic        capped;
  logic [63:0] vt;
  logic [64:0] dtrial;
  logic [33:0] sq_try;
  logic [63:0] srem_sh;
  logic [63:0] m2_hi, m2_lo;
  logic [33:0] t2c;

  assign busy = (st != S_IDLE);
  assign m2_hi = {32'd0, prod[63:32]} * {32'd0, samp_pkg::K2pi};
  assign m2_lo = {32'd0, prod[31:0]} * {32'd0, samp_pkg::K2pi};
  assign dtrial = {drem, dnum[63]} - {33'd0, dden};
  assign srem_sh = {srem[61:0], m2[63-2*scnt -: 2]};
  assign sq_try = {sres, 2'b01};
  // anything past 2^33 is beyond every sample time
  assign t2c = (dquo[63:33] != 31'd0) ? 34'h1_FFFF_FFFF : dquo[33:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_PROD;
      vr <= 32'd0; t1 <= '0; t2 <= '0; tt <= '0; s1 <= '0; s2 <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (go) st <= S_PROD;
        end
        S_PROD: begin
          prod <= {32'd0, len} * {32'd0, acc};
          st <= S_M2;
        end
        S_M2: begin
          m2 <= m2_hi + (m2_lo >> 32);
          srem <= '0; sres <= '0; scnt <= 5'd0;
          st <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle
          if ({30'd0, sq_try} <= srem_sh) begin
            srem <= srem_sh - {30'd0, sq_try};
            sres <= {sres[30:0], 1'b1};
          end else begin
            srem <= srem_sh;
            sres <= {sres[30:0], 1'b0};
          end
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) st <= S_VT;
        end
        S_VT: begin
          capped <= spd > sres;
          vr <= (spd > sres) ? sres : spd;
          dnum <= {32'd0, ((spd > sres) ? sres : spd)} * {32'd0, samp_pkg::PihQ30};
          dden <= acc;
          drem <= '0; dquo <= '0; dcnt <= 7'd0;
          st <= (((spd > sres) ? sres : spd) == 32'd0 || acc == 32'd0) ? S_FIN : S_DIV1;
        end
        S_DIV1: begin
          if (!dtrial[64]) begin
            drem <= dtrial[63:0]; dquo <= {dquo[62:0], 1'b1};
          end else begin
            drem <= {drem[62:0], dnum[63]}; dquo <= {dquo[62:0], 1'b0};
          end
          dnum <= {dnum[62:0], 1'b0};
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) st <= S_DIV2;
        end
        S_DIV2: begin
          // dquo holds vr*pih/a; set up l*2^16/vr next, reuse the divider
          if (dcnt == 7'd64) begin
            t1 <= dquo[47:14];
            vt <= {32'd0, vr} * {30'd0, dquo[47:14]};
            dnum <= {16'd0, len, 16'd0};
            dden <= vr;
            drem <= '0; dquo <= '0;
            dcnt <= 7'd0;
          end else begin
            if (!dtrial[64]) begin
              drem <= dtrial[63:0]; dquo <= {dquo[62:0], 1'b1};
            end else begin
              drem <= {drem[62:0], dnum[63]}; dquo <= {dquo[62:0], 1'b0};
            end
            dnum <= {dnum[62:0], 1'b0};
            dcnt <= dcnt + 7'd1;
            if (dcnt == 7'd63) st <= S_FIN;
          end
        end
        S_FIN: begin
          if (vr == 32'd0 || acc == 32'd0) begin
            vr <= 32'd0; t1 <= '0; t2 <= '0; tt <= '0; s1 <= '0; s2 <= '0;
          end else if (capped) begin
            s1 <= {1'b0, len[31:1]}; s2 <= '0; t2 <= t1; tt <= {t1[32:0], 1'b0};
          end else begin
            s1 <= vt[48:17];
            s2 <= (vt[63:16] >= {16'd0, len}) ? 32'd0 : len - vt[47:16];
            t2 <= (t2c < t1) ? t1 : t2c;
            tt <= t1 + ((t2c < t1) ? t1 : t2c);
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (go && st != S_IDLE) st <= S_PROD;
      if (st == S_DIV1 && dcnt == 7'd63) dcnt <= 7'd64;
    end
  end
endmodule

[design/sine_accel_motion_profile.sv]
// Sinusoidal-acceleration motion profile. Pulse start with time_now while busy is low; one
// sample is taken every cycle while busy is low, and its result appears on done with travelled,
// phase and speed_reached after a 32-cell divider row, a 16-cell rotation row and four register
// stages. Results cannot be stalled. After reset and after each write to the length, speed or
// acceleration register the block derives its profile (bit-serial square root and divisions),
// during which busy is high.
module sine_accel_motion_profile (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] time_now,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] travelled,
  output logic [1:0]  phase,
  output logic [31:0] speed_reached
);
  logic [31:0] len, spd, acc;
  logic        dbusy, go;
  logic [31:0] vr, s1, s2;
  logic [33:0] t1, t2, tt;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= 32'd0; spd <= 32'd65536; acc <= 32'd65536; go <= 1'b0;
    end else begin
      go <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          samp_pkg::RegLength: begin len <= cfg_data; go <= 1'b1; end
          samp_pkg::RegSpeed:  begin spd <= cfg_data; go <= 1'b1; end
          samp_pkg::RegAccel:  begin acc <= cfg_data; go <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  samp_derive u_der (.clk, .rst, .go, .len, .spd, .acc, .busy(dbusy),
    .vr, .t1, .t2, .tt, .s1, .s2);
  assign busy = dbusy | go;

  // entry: classify the sample
  samp_pkg::div_t dv [0:samp_pkg::DivSteps];
  logic [33:0] t34;
  assign t34 = {2'b00, time_now};
  always_comb begin
    dv[0] = '0;
    dv[0].tk.vld = start & ~busy;
    dv[0].tk.t = time_now;
    if (t34 >= tt) begin
      dv[0].tk.ph = samp_pkg::PhDone; dv[0].tk.base = len;
    end else if (t34 < t1) begin
      dv[0].tk.ph = samp_pkg::PhAccel; dv[0].tk.num = t34;
    end else if (t34 < t2) begin
      dv[0].tk.ph = samp_pkg::PhCruise; dv[0].tk.num = t34 - t1;
    end else begin
      dv[0].tk.ph = samp_pkg::PhDecel; dv[0].tk.num = t34 - t2;
      dv[0].tk.base = s1 + s2;
    end
    // u < t1 so 32 quotient steps give u*2^32/t1
    dv[0].rem = dv[0].tk.num;
  end

  for (genvar g = 0; g < samp_pkg::DivSteps; g++) begin : g_div
    samp_div_cell u_c (.clk, .rst, .t1, .din(dv[g]), .dout(dv[g+1]));
  end

  // fold and form the angle
  samp_pkg::cor_t cr [0:samp_pkg::SineSteps];
  logic [32:0] fq;
  logic [31:0] ff;
  logic [63:0] ang;
  always_comb begin
    fq = dv[samp_pkg::DivSteps].quo;
    ff = (fq > 33'h80000000) ? (32'd0 - fq[31:0]) : fq[31:0];
    ang = {32'd0, ff} * {32'd0, samp_pkg::PiQ30};
  end
  always_ff @(posedge clk) begin
    if (rst) cr[0].tk.vld <= 1'b0;
    else cr[0].tk.vld <= dv[samp_pkg::DivSteps].tk.vld;
    cr[0].tk.ph <= dv[samp_pkg::DivSteps].tk.ph;
    cr[0].tk.num <= dv[samp_pkg::DivSteps].tk.num;
    cr[0].tk.t <= dv[samp_pkg::DivSteps].tk.t;
    cr[0].tk.base <= dv[samp_pkg::DivSteps].tk.base;
    cr[0].x <= samp_pkg::GainQ30;
    cr[0].y <= '0;
    cr[0].z <= {2'b00, ang[63:32]};
  end

  for (genvar g = 0; g < samp_pkg::SineSteps; g++) begin : g_cor
    samp_cordic_cell u_c (.clk, .rst, .idx(5'(g)), .din(cr[g]), .dout(cr[g+1]));
  end

  // w = t1*sin/pi, then distance
  samp_pkg::cor_t ce;
  logic [30:0] ys;
  logic [63:0] p1;
  logic [63:0] p2;
  logic [1:0]  vld_o;
  logic [1:0]  ph_o [0:1];
  logic [33:0] num_o [0:1];
  logic [31:0] base_o [0:1];
  logic [33:0] w;
  logic [63:0] da, db;
  logic [34:0] sum;

  assign ce = cr[samp_pkg::SineSteps];
  assign ys = ce.y[33] ? 31'd0 : (ce.y > 34'sh40000000 ? 31'h40000000 : ce.y[30:0]);

  always_ff @(posedge clk) begin
    if (rst) vld_o <= 2'b00;
    else vld_o <= {vld_o[0], ce.tk.vld};
    p1 <= {30'd0, t1} * {33'd0, ys};
    ph_o[0] <= ce.tk.ph; num_o[0] <= ce.tk.num; base_o[0] <= ce.tk.base;
    p2 <= {30'd0, p1[63:30]} * {32'd0, samp_pkg::IpiQ32};
    ph_o[1] <= ph_o[0]; num_o[1] <= num_o[0]; base_o[1] <= base_o[0];
  end

  always_comb begin
    w = {2'b00, p2[63:32]};
    if (w > num_o[1]) w = num_o[1];
    da = '0; db = '0;
    case (ph_o[1])
      samp_pkg::PhAccel:  da = ({32'd0, vr} * {30'd0, num_o[1] - w}) >> 17;
      samp_pkg::PhCruise: da = ({32'd0, vr} * {30'd0, num_o[1]}) >> 16;
      samp_pkg::PhDecel: begin
        da = ({32'd0, vr} * {30'd0, num_o[1]}) >> 17;
        db = ({32'd0, vr} * {30'd0, w}) >> 17;
      end
      default: ;
    endcase
    sum = {3'd0, base_o[1]} + da[34:0] + db[34:0];
    if (ph_o[1] == samp_pkg::PhCruise) sum = {3'd0, s1} + da[34:0];
    if (ph_o[1] == samp_pkg::PhDone) sum = {3'd0, len};
    if (sum > {3'd0, len}) sum = {3'd0, len};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld_o[1];
    travelled <= sum[31:0];
    phase <= ph_o[1];
    speed_reached <= vr;
  end

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !dv[1].tk.vld) else $error("item taken while busy");
  a_done_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> travelled <= len) else $error("travelled past length");
  a_phase_done: assert property (@(posedge clk) disable iff (rst)
    done && phase == samp_pkg::PhDone |-> travelled == len) else $error("done not at length");
`endif
endmodule

[test/sine_accel_motion_profile_test.sv]
module sine_accel_motion_profile_test;

  typedef struct {
    logic [31:0] travelled;
    logic [1:0]  phase;
    logic [31:0] speed;
  } sample_t;

  class profile_board;
    logic [31:0] len, vreq, acc;
    logic [31:0] vr;
    longint unsigned t1, t2, tt, s1, s2;
    sample_t pending_samples[$];
    int errors;

    function new();
      errors = 0;
      len = 0;
      vreq = 32'd65536;
      acc = 32'd65536;
      derive();
    endfunction

    function automatic longint unsigned root(longint unsigned m);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > m) b = b >> 2;
      while (b != 0) begin
        if (m >= res + b) begin
          m = m - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function automatic longint unsigned mul_shift(longint unsigned x, longint unsigned y,
                                                  int s);
      logic [127:0] p;
      p = 128'(x) * 128'(y);
      return 64'(p >> s);
    endfunction

    function automatic longint signed arctan(int i);
      longint signed lo[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return lo[i];
      if (i <= 30) return 64'sd1 <<< (30 - i);
      return 0;
    endfunction

    // t1*sin(pi*u/t1)/pi, never more than u
    function automatic longint unsigned sine_offset(longint unsigned u);
      longint unsigned f, w;
      longint signed x, y, z, dx, dy;
      f = (u << 32) / t1;
      if (f > (64'd1 << 31)) f = (64'd1 << 32) - f;
      z = longint'(64'(128'(f) * 128'(samp_pkg::PiQ30) >> 32));
      x = 652032874;
      y = 0;
      for (int i = 0; i < samp_pkg::SineSteps && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - arctan(i);
        end else begin
          x = x + dx; y = y - dy; z = z + arctan(i);
        end
      end
      if (y < 0) y = 0;
      if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
      w = mul_shift(mul_shift(t1, longint'(y), 30), samp_pkg::IpiQ32, 32);
      return (w > u) ? u : w;
    endfunction

    function void derive();
      longint unsigned l, prod, m2, maxv, vt, c;
      bit capped;
      l = len;
      prod = 64'(len) * 64'(acc);
      m2 = mul_shift(prod, samp_pkg::K2pi, 32);
      maxv = root(m2);
      capped = 64'(vreq) > maxv;
      vr = capped ? maxv[31:0] : vreq;
      if (vr == 0 || acc == 0) begin
        vr = 0;
        t1 = 0; t2 = 0; tt = 0; s1 = 0; s2 = 0;
        return;
      end
      t1 = ((64'(vr) * 64'(samp_pkg::PihQ30)) / 64'(acc)) >> 14;
      if (capped) begin
        s1 = l >> 1;
        s2 = 0;
        t2 = t1;
        tt = 2 * t1;
      end else begin
        vt = 64'(vr) * t1;
        c = vt >> 16;
        s1 = vt >> 17;
        s2 = (c >= l) ? 0 : l - c;
        t2 = (l << 16) / 64'(vr);
        if (t2 < t1) t2 = t1;
        tt = t1 + t2;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        samp_pkg::RegLength: len = val;
        samp_pkg::RegSpeed:  vreq = val;
        samp_pkg::RegAccel:  acc = val;
        default: return;
      endcase
      derive();
    endfunction

    function void note_sample(logic [31:0] tn);
      longint unsigned t, s, w, u;
      sample_t e;
      t = tn;
      if (t >= tt) begin
        s = len;
        e.phase = samp_pkg::PhDone;
      end else if (t < t1) begin
        w = sine_offset(t);
        s = (64'(vr) * (t - w)) >> 17;
        e.phase = samp_pkg::PhAccel;
      end else if (t < t2) begin
        s = s1 + ((64'(vr) * (t - t1)) >> 16);
        e.phase = samp_pkg::PhCruise;
      end else begin
        u = t - t2;
        w = sine_offset(u);
        s = s1 + s2 + ((64'(vr) * u) >> 17) + ((64'(vr) * w) >> 17);
        e.phase = samp_pkg::PhDecel;
      end
      if (s > 64'(len)) s = len;
      e.travelled = s[31:0];
      e.speed = vr;
      pending_samples.push_back(e);
    endfunction

    function void check_sample(logic [31:0] trav, logic [1:0] ph, logic [31:0] spd);
      sample_t e;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result travelled=%h phase=%0d speed=%h",
                 $time, trav, ph, spd);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (trav !== e.travelled) begin
        $display("%0t: travelled expected %h actual %h", $time, e.travelled, trav);
        errors++;
      end
      if (ph !== e.phase) begin
        $display("%0t: phase expected %0d actual %0d", $time, e.phase, ph);
        errors++;
      end
      if (spd !== e.speed) begin
        $display("%0t: speed_reached expected %h actual %h", $time, e.speed, spd);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, cfg_we, done;
  logic [31:0] time_now, cfg_data, travelled, speed_reached;
  logic [1:0]  cfg_index, phase;

  profile_board board;
  int accepted;
  int cycles;
  bit no_idle;

  localparam int CycleLimit = 600000;
  // an index with no register behind it
  localparam logic [1:0] RegNone = 2'd3;

  sine_accel_motion_profile dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .time_now(time_now),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .travelled(travelled), .phase(phase), .speed_reached(speed_reached)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      board.note_sample(time_now);
      accepted <= accepted + 1;
    end
    if (!rst && done) board.check_sample(travelled, phase, speed_reached);
    if (cycles > CycleLimit) begin
      $display("sine_accel_motion_profile verification failed");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(logic [31:0] t);
    int n;
    start <= 1;
    time_now <= t;
    n = accepted;
    wait (accepted != n);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending_samples.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
    repeat (3) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] l, logic [31:0] v, logic [31:0] a);
    write_reg(samp_pkg::RegLength, l);
    write_reg(samp_pkg::RegSpeed, v);
    write_reg(samp_pkg::RegAccel, a);
  endtask

  function automatic logic [31:0] clip(longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // mostly inside the motion, some near the phase edges, some anywhere
  function automatic logic [31:0] pick_time();
    longint unsigned span;
    int k;
    k = $urandom_range(0, 9);
    span = board.tt + board.tt / 8 + 1;
    if (k == 0 || span > 64'hFFFF_FFFF) return $urandom;
    if (k == 1) return clip(board.t1 + $urandom_range(0, 6) - 3);
    if (k == 2) return clip(board.t2 + $urandom_range(0, 6) - 3);
    if (k == 3) return clip(board.tt + $urandom_range(0, 6) - 3);
    return $urandom_range(0, span[31:0]);
  endfunction

  task automatic directed_times();
    send_item(0);
    send_item(32'hFFFF_FFFF);
    send_item(clip(board.t1 / 2));
    send_item(clip(board.t1 - 1));
    send_item(clip(board.t1));
    send_item(clip((board.t1 + board.t2) / 2));
    send_item(clip(board.t2 - 1));
    send_item(clip(board.t2));
    send_item(clip(board.t2 + board.t1 / 2));
    send_item(clip(board.tt - 1));
    send_item(clip(board.tt));
  endtask

  task automatic random_times(int n);
    for (int i = 0; i < n; i++) send_item(pick_time());
  endtask

  initial begin
    board = new();
    rst = 1;
    start = 0;
    time_now = 0;
    cfg_we = 0;
    cfg_index = samp_pkg::RegLength;
    cfg_data = 0;
    accepted = 0;
    cycles = 0;
    no_idle = 0;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset profile: no motion at all
    send_item(0);
    send_item(32'h0001_0000);
    configure(32'd655360, 32'd131072, 32'd262144);
    directed_times();
    configure(32'd655360, 32'hFFFF_FFFF, 32'd262144);  // speed capped, no cruise
    directed_times();
    write_reg(RegNone, 32'h1234_5678);
    send_item(clip(board.t1 / 3));
    random_times(60);
    drain();
    random_times(40);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_times(40);
    configure(32'hFFFF_FFFF, 32'd1, 32'd1);
    random_times(40);
    configure(32'd1, 32'd1, 32'hFFFF_FFFF);
    random_times(30);
    configure(32'd0, 32'd65536, 32'd65536);
    random_times(20);
    for (int p = 0; p < 12; p++) begin
      if (p == 11) no_idle = 1;
      if ($urandom_range(0, 3) == 0)
        configure($urandom, $urandom | 1, $urandom | 1);
      else
        configure($urandom_range(32'h1_0000, 32'h400_0000),
                  $urandom_range(32'h1000, 32'h100_0000),
                  $urandom_range(32'h4000, 32'h40_0000));
      random_times(105);
    end

    start <= 0;
    while (board.pending_samples.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (board.errors == 0)
      $display("sine_accel_motion_profile verification clean");
    else
      $display("sine_accel_motion_profile verification failed");
    $finish;
  end
endmodule

[files.f]
design/samp_pkg.sv
design/samp_div_cell.sv
design/samp_cordic_cell.sv
design/samp_derive.sv
design/sine_accel_motion_profile.sv
test/sine_accel_motion_profile_test.sv
